### sv/mlk_pkg.sv
// Shared types, character codes and the Morse element table for the letter keyer.
package mlk_pkg;

    localparam logic [7:0] LETTER_A   = 8'h41;
    localparam logic [7:0] LETTER_Z   = 8'h5A;
    localparam logic [7:0] WORD_SPACE = 8'h20;

    // High nibble: element count. Low nibble: elements from bit 3 down, 1 = dash, 0 = dot.
    localparam logic [7:0] MORSE_TABLE [26] = '{
        8'h24, 8'h48, 8'h4A, 8'h38, 8'h10, 8'h42, 8'h3C, 8'h40, 8'h20, 8'h47,
        8'h3A, 8'h44, 8'h2C, 8'h28, 8'h3E, 8'h46, 8'h4D, 8'h34, 8'h30, 8'h18,
        8'h32, 8'h41, 8'h36, 8'h49, 8'h4B, 8'h4C
    };

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;      // capture and decode the incoming character
        logic elem_adv;  // advance one unit inside the current element
        logic gap_dec;   // one trailing off unit has been sent
        logic emit;      // write a word into the output register
        logic key;
        logic last;
        logic bad;
    } t_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic out_free;    // output register can take a word this cycle
        logic char_bad;    // incoming character is neither a letter nor a space
        logic count_zero;  // no elements to send
        logic count_last;  // current element is the final one
        logic elem_end;    // current unit closes the element
        logic key_bit;     // key level of the current element unit
        logic gap_last;    // current off unit is the final trailing one
    } t_stat;

endpackage

### sv/mlk_ifs.sv
// Valid/ready channel interfaces for characters in and key units out.
interface mlk_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface mlk_unit_if;
    logic valid;
    logic ready;
    logic key_on;
    logic last_unit;
    logic bad_character;

    modport source (output valid, output key_on, output last_unit, output bad_character,
                    input ready);
    modport sink   (input valid, input key_on, input last_unit, input bad_character,
                    output ready);
endinterface

### sv/morse_letter_keyer_top.sv
// Top level of the Morse letter keyer: one character in, a run of key units out.
// The first unit (the fetch off unit) is emitted from the fetch state once the output is free.
// Throughput: a letter gives 3 + pattern units (5 to 14), a space 4, a bad code 1;
// one unit per cycle while the output is free; the input stays closed until the end unit.
// The output register lets the final unit wait while the next character is taken.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output.
module morse_letter_keyer_top
    import mlk_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    mlk_char_if.sink        i_char,
    mlk_unit_if.source      o_unit
);

    // Commands flow from the sequencer to the datapath, status flows back.
    t_cmd  w_cmd;
    t_stat w_stat;

    // The sequencer decides which kind of unit goes out next: the fetch unit,
    // the on/off units of each element, the trailing off units, and the end unit.
    mlk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_char.valid),
        .i_stat     (w_stat),
        .o_in_ready (i_char.ready),
        .o_cmd      (w_cmd)
    );

    // The datapath decodes the character through the element table, counts
    // elements and gap units, and holds the outgoing word until it is taken.
    mlk_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_character     (i_char.character),
        .i_out_ready     (o_unit.ready),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_out_valid     (o_unit.valid),
        .o_key_on        (o_unit.key_on),
        .o_last_unit     (o_unit.last_unit),
        .o_bad_character (o_unit.bad_character)
    );

endmodule

### sv/mlk_dpath.sv
// Datapath: character decode, element and gap counters, and the output register.
module mlk_dpath
    import mlk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_character,
    input  logic       i_out_ready,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    output logic       o_out_valid,
    output logic       o_key_on,
    output logic       o_last_unit,
    output logic       o_bad_character
);

    logic [7:0] w_offset;
    logic [4:0] w_index;
    logic [7:0] w_code;
    logic       w_letter;
    logic       w_space;

    logic [3:0] r_elems;
    logic [2:0] r_count;
    logic [1:0] r_phase;
    logic [1:0] r_gap;
    logic       r_out_valid;
    logic       r_key;
    logic       r_last;
    logic       r_bad;

    always_comb begin
        w_letter = (i_character >= LETTER_A) && (i_character <= LETTER_Z);
        w_space  = (i_character == WORD_SPACE);
        w_offset = i_character - LETTER_A;
        w_index  = w_letter ? w_offset[4:0] : 5'd0;
        w_code   = MORSE_TABLE[w_index];
    end

    always_comb begin
        o_stat.out_free   = !r_out_valid || i_out_ready;
        o_stat.char_bad   = !(w_letter || w_space);
        o_stat.count_zero = (r_count == 3'd0);
        o_stat.count_last = (r_count == 3'd1);
        // A dot is on,off and a dash is on,on,off.
        o_stat.elem_end   = r_elems[3] ? (r_phase == 2'd2) : (r_phase == 2'd1);
        o_stat.key_bit    = (r_phase == 2'd0) || ((r_phase == 2'd1) && r_elems[3]);
        o_stat.gap_last   = (r_gap == 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_elems <= w_code[3:0];
            r_count <= w_space ? 3'd0 : w_code[6:4];
            r_gap   <= w_space ? 2'd2 : 2'd1;
            r_phase <= 2'd0;
        end else if (i_cmd.elem_adv) begin
            if (o_stat.elem_end) begin
                r_elems <= {r_elems[2:0], 1'b0};
                r_count <= r_count - 3'd1;
                r_phase <= 2'd0;
            end else begin
                r_phase <= r_phase + 2'd1;
            end
        end else if (i_cmd.gap_dec) begin
            r_gap <= r_gap - 2'd1;
        end
        if (i_cmd.emit) begin
            r_key  <= i_cmd.key;
            r_last <= i_cmd.last;
            r_bad  <= i_cmd.bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_key_on        = r_key;
    assign o_last_unit     = r_last;
    assign o_bad_character = r_bad;

endmodule

### sv/mlk_ctrl.sv
// Sequencer: walks fetch, element, gap and end units for one character.
module mlk_ctrl
    import mlk_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BAD,
        ST_FETCH,
        ST_ELEM,
        ST_GAP,
        ST_END
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.char_bad ? ST_BAD : ST_FETCH;
                end
            end
            ST_BAD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    o_cmd.bad  = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_FETCH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.count_zero ? ST_GAP : ST_ELEM;
                end
            end
            ST_ELEM: begin
                if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.key      = i_stat.key_bit;
                    o_cmd.elem_adv = 1'b1;
                    if (i_stat.elem_end && i_stat.count_last) begin
                        n_state = ST_GAP;
                    end
                end
            end
            ST_GAP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.gap_dec = 1'b1;
                    if (i_stat.gap_last) begin
                        n_state = ST_END;
                    end
                end
            end
            ST_END: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/mlk_checker.sv
// Port-level checker for the keyer and its bind to the top level.
module mlk_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_key_on,
    input logic i_last_unit,
    input logic i_bad_character
);

    // A stalled output word holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_key_on) && $stable(i_last_unit)
             && $stable(i_bad_character)))
        else $error("output word changed while stalled");

    // One character at a time: after acceptance the input is closed.
    a_one_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after a character was accepted");

    // A bad code gives a single off word that closes the character.
    a_bad_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_bad_character) |-> (i_last_unit && !i_key_on))
        else $error("bad character word not a lone off unit");

    // The end unit of a character is always off.
    a_last_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_last_unit) |-> !i_key_on)
        else $error("final unit keyed on");

endmodule

bind morse_letter_keyer_top mlk_checker u_mlk_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_char.valid),
    .i_in_ready      (i_char.ready),
    .i_out_valid     (o_unit.valid),
    .i_out_ready     (o_unit.ready),
    .i_key_on        (o_unit.key_on),
    .i_last_unit     (o_unit.last_unit),
    .i_bad_character (o_unit.bad_character)
);

### bench/morse_letter_keyer_top_tb.sv
// Self-checking testbench for the Morse letter keyer: directed and random characters.
module morse_letter_keyer_top_tb;
    import mlk_pkg::*;

    // The run is cut off here if the results stop coming.
    localparam int CYCLE_LIMIT  = 200000;
    // Settling time after the last expected word.
    localparam int DRAIN_CYCLES = 20;
    // Percentage of cycles in which a side idles while idling is enabled.
    localparam int IDLE_PCT     = 7;

    // One key unit as it appears on the output channel.
    typedef struct packed {
        logic key_on;
        logic last_unit;
        logic bad_character;
    } t_key_unit;

    logic i_clk;
    logic i_rst_n;

    mlk_char_if char_ch ();
    mlk_unit_if unit_ch ();

    morse_letter_keyer_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_ch),
        .o_unit  (unit_ch)
    );

    // Key units still owed by the block, oldest first.
    t_key_unit expected_units[$];
    int        mismatch_count;
    int        cycle_count;
    // Idle rates of the sender and the receiver; zero gives a steady stream.
    int        sender_idle_pct;
    int        receiver_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Dots and dashes of each letter, written out as they are spoken.
    function automatic string morse_elements(input logic [7:0] ch);
        case (ch)
            "A": return ".-";
            "B": return "-...";
            "C": return "-.-.";
            "D": return "-..";
            "E": return ".";
            "F": return "..-.";
            "G": return "--.";
            "H": return "....";
            "I": return "..";
            "J": return ".---";
            "K": return "-.-";
            "L": return ".-..";
            "M": return "--";
            "N": return "-.";
            "O": return "---";
            "P": return ".--.";
            "Q": return "--.-";
            "R": return ".-.";
            "S": return "...";
            "T": return "-";
            "U": return "..-";
            "V": return "...-";
            "W": return ".--";
            "X": return "-..-";
            "Y": return "-.--";
            "Z": return "--..";
            default: return "";
        endcase
    endfunction

    function automatic void add_unit(input logic key, input logic last, input logic bad);
        t_key_unit u;
        u.key_on        = key;
        u.last_unit     = last;
        u.bad_character = bad;
        expected_units.push_back(u);
    endfunction

    // Appends the full keying of one character to the queue of owed units.
    // A character outside A-Z and the word space yields one flagged off unit.
    // Otherwise the run opens with the fetch off unit, then the elements
    // (a dot is on,off and a dash is on,on,off), then the trailing gap (one
    // off unit for a letter, two for a space), and closes with the end unit.
    function automatic void predict_keying(input logic [7:0] ch);
        string elems;
        int    i;
        if (ch == WORD_SPACE) begin
            add_unit(1'b0, 1'b0, 1'b0);
            add_unit(1'b0, 1'b0, 1'b0);
            add_unit(1'b0, 1'b0, 1'b0);
            add_unit(1'b0, 1'b1, 1'b0);
        end else if (ch >= LETTER_A && ch <= LETTER_Z) begin
            elems = morse_elements(ch);
            add_unit(1'b0, 1'b0, 1'b0);
            for (i = 0; i < elems.len(); i++) begin
                add_unit(1'b1, 1'b0, 1'b0);
                if (elems[i] == "-") begin
                    add_unit(1'b1, 1'b0, 1'b0);
                end
                add_unit(1'b0, 1'b0, 1'b0);
            end
            add_unit(1'b0, 1'b0, 1'b0);
            add_unit(1'b0, 1'b1, 1'b0);
        end else begin
            add_unit(1'b0, 1'b1, 1'b1);
        end
    endfunction

    // Sends one character word. Valid stays high after acceptance so that a
    // back-to-back word needs no second assignment in the same time step; it
    // is lowered only on an idle cycle or by a drain.
    task automatic send_character(input logic [7:0] ch);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            char_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.character <= ch;
        do begin
            @(posedge i_clk);
        end while (char_ch.ready !== 1'b1);
        predict_keying(ch);
    endtask

    // Holds the sender off until every owed key unit has come out.
    task automatic wait_for_drain();
        char_ch.valid <= 1'b0;
        while (expected_units.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] random_letter();
        return LETTER_A + 8'($urandom_range(0, 25));
    endfunction

    // Well-formed text: mostly letters with an occasional word space.
    function automatic logic [7:0] random_text_char();
        if ($urandom_range(0, 99) < 15) begin
            return WORD_SPACE;
        end
        return random_letter();
    endfunction

    // Both ends of the alphabet, the shortest and longest patterns, and the
    // all-dot and all-dash letters.
    task automatic test_letter_extremes();
        send_character("A");
        send_character("Z");
        send_character("E");
        send_character("T");
        send_character("Q");
        send_character("J");
        send_character("H");
        send_character("O");
    endtask

    // Two word spaces in a row, so a space follows a space directly.
    task automatic test_word_space();
        send_character(WORD_SPACE);
        send_character(WORD_SPACE);
    endtask

    // Codes just outside the letter range and around the space, lower case,
    // zero and all ones; each must give a single flagged unit.
    task automatic test_bad_codes();
        send_character(8'h00);
        send_character(8'hFF);
        send_character(LETTER_A - 8'd1);
        send_character(LETTER_Z + 8'd1);
        send_character("a");
        send_character("z");
        send_character(WORD_SPACE - 8'd1);
        send_character(WORD_SPACE + 8'd1);
        send_character(8'h80);
        send_character(8'h7F);
    endtask

    // A few letters, then the sender stops until the output is empty.
    task automatic test_drain_pause();
        int n;
        for (n = 0; n < 5; n++) begin
            send_character(random_letter());
        end
        wait_for_drain();
    endtask

    // Random text with idling on both sides.
    task automatic test_random_text(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            send_character(random_text_char());
        end
    endtask

    // Random text with neither side idling, so words run back to back.
    task automatic test_steady_stream(input int count);
        int n;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        for (n = 0; n < count; n++) begin
            send_character(random_text_char());
        end
        sender_idle_pct   = IDLE_PCT;
        receiver_idle_pct = IDLE_PCT;
    endtask

    // Any code at all, bad ones mixed in with text.
    task automatic test_random_noise(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(0, 1) == 0) begin
                send_character(8'($urandom_range(0, 255)));
            end else begin
                send_character(random_text_char());
            end
        end
    endtask

    // The receiver stalls at random; ready starts low and is redrawn every cycle.
    initial begin
        unit_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            unit_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Every accepted key unit is compared with the oldest owed unit. Values are
    // read at the edge before any nonblocking update of that edge takes effect.
    initial begin
        t_key_unit got;
        t_key_unit want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && unit_ch.valid === 1'b1 && unit_ch.ready === 1'b1) begin
                got.key_on        = unit_ch.key_on;
                got.last_unit     = unit_ch.last_unit;
                got.bad_character = unit_ch.bad_character;
                if (expected_units.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("Unexpected key unit at cycle %0d: key %b last %b bad %b",
                                 cycle_count, got.key_on, got.last_unit, got.bad_character);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_units.pop_front();
                    if (got.key_on !== want.key_on || got.last_unit !== want.last_unit ||
                        got.bad_character !== want.bad_character) begin
                        if (mismatch_count < 10) begin
                            $display({"Key unit mismatch at cycle %0d: expected key %b last %b ",
                                      "bad %b, got key %b last %b bad %b"},
                                     cycle_count, want.key_on, want.last_unit,
                                     want.bad_character, got.key_on, got.last_unit,
                                     got.bad_character);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d key units owed",
                 cycle_count, expected_units.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        mismatch_count    = 0;
        sender_idle_pct   = IDLE_PCT;
        receiver_idle_pct = IDLE_PCT;
        i_rst_n           <= 1'b0;
        char_ch.valid     <= 1'b0;
        char_ch.character <= 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_letter_extremes();
        test_word_space();
        test_bad_codes();
        test_drain_pause();
        test_random_text(100);
        test_steady_stream(40);
        test_random_noise(45);

        // Let the last character play out, then give the block time to show
        // any stray word before the verdict.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_units.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
sv/mlk_pkg.sv
sv/mlk_ifs.sv
sv/mlk_dpath.sv
sv/mlk_ctrl.sv
sv/morse_letter_keyer_top.sv
sv/mlk_checker.sv
bench/morse_letter_keyer_top_tb.sv
